// ----- rtl/pse_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pse_pkg
// shared types and constants of the postfix stack evaluator
// ----------------------------------------------------------------------------
package pse_pkg;

	// symbol characters
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_STAR  = 8'd42;
	localparam logic [7:0] CH_SLASH = 8'd47;
	localparam logic [7:0] CH_PCT   = 8'd37;
	localparam logic [7:0] CH_CARET = 8'd94;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// result port widths
	localparam int RESULT_W = 32;
	localparam int DEPTH_W  = 5;

	typedef enum logic [2:0] {
		STAT_OK    = 3'd0,
		STAT_UNDER = 3'd1,
		STAT_OVER  = 3'd2,
		STAT_DIVZ  = 3'd3,
		STAT_BAD   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		OP_PUSH,
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_MOD,
		OP_POW,
		OP_BAD
	} op_t;

	// classified symbol handed from front to back
	typedef struct packed {
		op_t        op;
		logic [3:0] digit;
		logic       last;
	} item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_MUL,
		S_DIV,
		S_POW_CHK,
		S_POW_MA,
		S_POW_SQ,
		S_FIN
	} state_t;

endpackage
`default_nettype wire

// ----- rtl/pse_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pse_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/pse_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pse_front
// takes symbols, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module pse_front
	import pse_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] symbol,
	input  wire logic       last_symbol,
	input  wire logic       push,
	output logic            full,
	output logic            head_valid,
	output item_t           head,
	input  wire logic       head_pop
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	item_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	item_t          cls;
	logic           do_push;
	logic           do_pop;

	// symbol classification
	always_comb begin
		cls.last  = last_symbol;
		cls.digit = '0;
		cls.op    = OP_BAD;
		if (symbol inside {[CH_ZERO:CH_NINE]}) begin
			cls.op    = OP_PUSH;
			cls.digit = 4'(symbol - CH_ZERO);
		end else begin
			case (symbol)
				CH_PLUS:  cls.op = OP_ADD;
				CH_MINUS: cls.op = OP_SUB;
				CH_STAR:  cls.op = OP_MUL;
				CH_SLASH: cls.op = OP_DIV;
				CH_PCT:   cls.op = OP_MOD;
				CH_CARET: cls.op = OP_POW;
				default:  cls.op = OP_BAD;
			endcase
		end
	end

	assign full       = (count_q == CW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = head_pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/pse_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pse_mul
// iterative wrapping multiplier, one 8-bit slice of the multiplier a cycle
// ----------------------------------------------------------------------------
module pse_mul #(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DATA_WIDTH-1:0] op_a,
	input  wire logic [DATA_WIDTH-1:0] op_b,
	output logic                       done,
	output logic      [DATA_WIDTH-1:0] prod
);

	localparam int MB = 8;

	logic                     busy_q;
	logic                     done_q;
	logic [DATA_WIDTH-1:0]    a_sh_q;
	logic [DATA_WIDTH-1:0]    b_sh_q;
	logic [DATA_WIDTH-1:0]    acc_q;
	logic [DATA_WIDTH+MB-1:0] partial;
	logic [DATA_WIDTH-1:0]    b_next;

	assign partial = a_sh_q * b_sh_q[MB-1:0];
	assign b_next  = b_sh_q >> MB;
	assign done    = done_q;
	assign prod    = acc_q;

	always_ff @(posedge clk) begin
		if (start) begin
			a_sh_q <= op_a;
			b_sh_q <= op_b;
			acc_q  <= '0;
		end else if (busy_q) begin
			a_sh_q <= a_sh_q << MB;
			b_sh_q <= b_next;
			acc_q  <= acc_q + partial[DATA_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (b_next == '0)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/pse_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pse_div
// restoring signed divider, one quotient bit a cycle, truncating toward zero
// ----------------------------------------------------------------------------
module pse_div #(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DATA_WIDTH-1:0] dividend,
	input  wire logic [DATA_WIDTH-1:0] divisor,
	output logic                       done,
	output logic      [DATA_WIDTH-1:0] quotient,
	output logic      [DATA_WIDTH-1:0] remainder
);

	localparam int CW = $clog2(DATA_WIDTH + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CW-1:0]         cnt_q;
	logic [DATA_WIDTH-1:0] quo_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] dvs_q;
	logic                  neg_q_q;
	logic                  neg_r_q;
	logic [DATA_WIDTH:0]   rem_sh;
	logic                  ge;
	logic [DATA_WIDTH:0]   rem_sub;

	function automatic logic [DATA_WIDTH-1:0] mag(input logic [DATA_WIDTH-1:0] v);
		return v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
	endfunction

	assign rem_sh  = {rem_q, quo_q[DATA_WIDTH-1]};
	assign ge      = (rem_sh >= {1'b0, dvs_q});
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	assign done      = done_q;
	assign quotient  = neg_q_q ? (~quo_q + 1'b1) : quo_q;
	assign remainder = neg_r_q ? (~rem_q + 1'b1) : rem_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q   <= mag(dividend);
			rem_q   <= '0;
			dvs_q   <= mag(divisor);
			neg_q_q <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
			neg_r_q <= dividend[DATA_WIDTH-1];
		end else if (busy_q) begin
			quo_q <= {quo_q[DATA_WIDTH-2:0], ge};
			rem_q <= ge ? rem_sub[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DATA_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/pse_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pse_back
// carries out classified symbols on the operand stack and holds the result
// ----------------------------------------------------------------------------
module pse_back
	import pse_pkg::*;
#(
	parameter int STACK_DEPTH = 16,
	parameter int DATA_WIDTH  = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                head_valid,
	input  wire item_t               head,
	output logic                     head_pop,
	output logic                     out_valid,
	output logic signed [RESULT_W-1:0] out_value,
	output status_t                  out_status,
	output logic        [DEPTH_W-1:0] out_depth,
	input  wire logic                out_pop
);

	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int AW  = $clog2(STACK_DEPTH);
	localparam int DW  = DATA_WIDTH;

	state_t          state_q, state_d;
	logic [SPW-1:0]  sp_q, sp_d;
	logic [DW-1:0]   tos_q, tos_d;
	status_t         err_q, err_d;
	item_t           cur_q, cur_d;
	logic [DW-1:0]   acc_q, acc_d;
	logic [DW-1:0]   base_q, base_d;
	logic [DW-1:0]   e_q, e_d;

	logic                       out_valid_q;
	logic signed [RESULT_W-1:0] out_value_q, out_value_d;
	status_t                    out_status_q, out_status_d;
	logic [DEPTH_W-1:0]         out_depth_q, out_depth_d;
	logic                       out_load;

	logic            start;
	logic            go_read;
	logic            sp_lt2;
	logic            sp_full;
	logic            e_hi_zero;
	state_t          fin_or_idle;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [AW-1:0]   ram_raddr;
	logic [DW-1:0]   ram_rdata;

	logic            mul_start;
	logic [DW-1:0]   mul_a, mul_b;
	logic            mul_done;
	logic [DW-1:0]   mul_prod;

	logic            div_start;
	logic            div_done;
	logic [DW-1:0]   div_quo, div_rem;

	assign sp_lt2      = (sp_q < SPW'(2));
	assign sp_full     = (sp_q == SPW'(STACK_DEPTH));
	assign e_hi_zero   = ((e_q >> 1) == '0);
	assign fin_or_idle = cur_q.last ? S_FIN : S_IDLE;
	assign start       = (state_q == S_IDLE) && head_valid && (!head.last || !out_valid_q);
	assign go_read     = (err_q == STAT_OK) && (head.op != OP_PUSH) && (head.op != OP_BAD)
		&& !sp_lt2;
	assign ram_waddr   = AW'(sp_q - 1'b1);
	assign ram_raddr   = AW'(sp_q - SPW'(2));
	assign head_pop    = start;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (go_read) begin
						state_d = S_READ;
					end else if (head.last) begin
						state_d = S_FIN;
					end
				end
			end
			S_READ: begin
				case (cur_q.op)
					OP_MUL: state_d = S_MUL;
					OP_DIV, OP_MOD: begin
						state_d = (tos_q == '0) ? fin_or_idle : S_DIV;
					end
					OP_POW: begin
						state_d = tos_q[DW-1] ? fin_or_idle : S_POW_CHK;
					end
					default: state_d = fin_or_idle;
				endcase
			end
			S_MUL: begin
				if (mul_done) begin
					state_d = fin_or_idle;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_d = fin_or_idle;
				end
			end
			S_POW_CHK: begin
				if (e_q == '0) begin
					state_d = fin_or_idle;
				end else if (e_q[0]) begin
					state_d = S_POW_MA;
				end else begin
					state_d = S_POW_SQ;
				end
			end
			S_POW_MA: begin
				if (mul_done) begin
					state_d = e_hi_zero ? S_POW_CHK : S_POW_SQ;
				end
			end
			S_POW_SQ: begin
				if (mul_done) begin
					state_d = S_POW_CHK;
				end
			end
			S_FIN:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// datapath control
	always_comb begin
		sp_d         = sp_q;
		tos_d        = tos_q;
		err_d        = err_q;
		cur_d        = cur_q;
		acc_d        = acc_q;
		base_d       = base_q;
		e_d          = e_q;
		ram_we       = 1'b0;
		mul_start    = 1'b0;
		mul_a        = base_q;
		mul_b        = base_q;
		div_start    = 1'b0;
		out_load     = 1'b0;
		out_value_d  = '0;
		out_status_d = err_q;
		out_depth_d  = DEPTH_W'(sp_q);
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cur_d = head;
					if (err_q == STAT_OK) begin
						case (head.op)
							OP_PUSH: begin
								if (sp_full) begin
									err_d = STAT_OVER;
								end else begin
									ram_we = (sp_q != '0);
									tos_d  = DW'(head.digit);
									sp_d   = sp_q + 1'b1;
								end
							end
							OP_BAD: err_d = STAT_BAD;
							default: begin
								if (sp_lt2) begin
									err_d = STAT_UNDER;
								end
							end
						endcase
					end
				end
			end
			S_READ: begin
				case (cur_q.op)
					OP_ADD: begin
						tos_d = ram_rdata + tos_q;
						sp_d  = sp_q - 1'b1;
					end
					OP_SUB: begin
						tos_d = ram_rdata - tos_q;
						sp_d  = sp_q - 1'b1;
					end
					OP_MUL: begin
						mul_start = 1'b1;
						mul_a     = ram_rdata;
						mul_b     = tos_q;
					end
					OP_DIV, OP_MOD: begin
						if (tos_q == '0) begin
							err_d = STAT_DIVZ;
						end else begin
							div_start = 1'b1;
						end
					end
					OP_POW: begin
						if (tos_q[DW-1]) begin
							tos_d = DW'(1);
							sp_d  = sp_q - 1'b1;
						end else begin
							acc_d  = DW'(1);
							base_d = ram_rdata;
							e_d    = tos_q;
						end
					end
					default: begin
					end
				endcase
			end
			S_MUL: begin
				if (mul_done) begin
					tos_d = mul_prod;
					sp_d  = sp_q - 1'b1;
				end
			end
			S_DIV: begin
				if (div_done) begin
					tos_d = (cur_q.op == OP_MOD) ? div_rem : div_quo;
					sp_d  = sp_q - 1'b1;
				end
			end
			S_POW_CHK: begin
				if (e_q == '0) begin
					tos_d = acc_q;
					sp_d  = sp_q - 1'b1;
				end else begin
					mul_start = 1'b1;
					if (e_q[0]) begin
						mul_a = acc_q;
					end
				end
			end
			S_POW_MA: begin
				if (mul_done) begin
					acc_d = mul_prod;
					if (e_hi_zero) begin
						e_d = '0;
					end else begin
						mul_start = 1'b1;
					end
				end
			end
			S_POW_SQ: begin
				if (mul_done) begin
					base_d = mul_prod;
					e_d    = e_q >> 1;
				end
			end
			S_FIN: begin
				out_load = 1'b1;
				if (err_q == STAT_OK && sp_q != '0) begin
					out_value_d  = RESULT_W'($signed(tos_q));
					out_status_d = STAT_OK;
					out_depth_d  = DEPTH_W'(sp_q - 1'b1);
				end else if (err_q == STAT_OK) begin
					out_status_d = STAT_UNDER;
				end
				sp_d  = '0;
				err_d = STAT_OK;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		tos_q  <= tos_d;
		cur_q  <= cur_d;
		acc_q  <= acc_d;
		base_q <= base_d;
		e_q    <= e_d;
		if (out_load) begin
			out_value_q  <= out_value_d;
			out_status_q <= out_status_d;
			out_depth_q  <= out_depth_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sp_q        <= '0;
			err_q       <= STAT_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sp_q    <= sp_d;
			err_q   <= err_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_status = out_status_q;
	assign out_depth  = out_depth_q;

	// entries below the top; the top itself lives in tos_q
	pse_ram #(
		.WIDTH (DW),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (tos_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pse_mul #(
		.DATA_WIDTH (DW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	pse_div #(
		.DATA_WIDTH (DW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (ram_rdata),
		.divisor   (tos_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

endmodule
`default_nettype wire

// ----- rtl/postfix_stack_evaluator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// evaluates postfix expressions arriving one symbol per transaction
// ----------------------------------------------------------------------------
//
// channel  | direction | handshake         | payload
// ---------+-----------+-------------------+-----------------------------------
// symbols  | in        | push / full       | symbol, last_symbol
// results  | out       | pop / empty       | result_value, status, depth_left
//
// a digit push is done in S_IDLE, + and - add a stack read in S_READ, * then
// waits in S_MUL for the multiplier, which works through the second operand in
// 8-bit slices up to its highest nonzero one (one to DATA_WIDTH/8 rounded up);
// / and % wait in S_DIV for the one-bit-a-cycle divider
// ^ runs square-and-multiply on the same 8-bit slice multiplier, up to two
// multiplies per exponent bit; the symbol marked last adds the S_FIN state
// reset leaves the stack empty with no error; stack memory needs no clearing
// a two-entry queue keeps taking symbols while the back end works or a result
// waits; only a last symbol waits for the result register to drain
// ----------------------------------------------------------------------------
module postfix_stack_evaluator
	import pse_pkg::*;
#(
	parameter int STACK_DEPTH = 16,
	parameter int DATA_WIDTH  = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// symbol side
	input  wire logic [7:0]                 symbol,
	input  wire logic                       last_symbol,
	input  wire logic                       push,
	output logic                            full,
	// result side
	output logic signed [RESULT_W-1:0]      result_value,
	output logic        [2:0]               status,
	output logic        [DEPTH_W-1:0]       depth_left,
	output logic                            empty,
	input  wire logic                       pop
);

	// classified symbols waiting for the back end
	item_t   head;
	logic    head_valid;
	logic    head_pop;

	// result register
	logic    out_valid;
	status_t out_status;

	// front end: classify each symbol and queue it
	pse_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.symbol      (symbol),
		.last_symbol (last_symbol),
		.push        (push),
		.full        (full),
		.head_valid  (head_valid),
		.head        (head),
		.head_pop    (head_pop)
	);

	// back end: stack, arithmetic units and the result register
	pse_back #(
		.STACK_DEPTH (STACK_DEPTH),
		.DATA_WIDTH  (DATA_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop),
		.out_valid  (out_valid),
		.out_value  (result_value),
		.out_status (out_status),
		.out_depth  (depth_left),
		.out_pop    (pop)
	);

	// a result transaction is offered while the result register is loaded
	assign empty  = !out_valid;
	assign status = out_status;

endmodule
`default_nettype wire

// ----- rtl/pse_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pse_checker
// port level checks on the postfix stack evaluator
// ----------------------------------------------------------------------------
module pse_checker
	import pse_pkg::*;
#(
	parameter int STACK_DEPTH = 16
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic [RESULT_W-1:0]  result_value,
	input wire logic [2:0]           status,
	input wire logic [DEPTH_W-1:0]   depth_left,
	input wire logic                 empty,
	input wire logic                 pop
);

	// an offered result holds until taken
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result_value) && $stable(status)
			&& $stable(depth_left)))
		else $error("result changed while waiting");

	// any error reports a zero value
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != 3'(STAT_OK)) |-> (result_value == '0))
		else $error("nonzero value with error status");

	// underflow only happens with fewer than two entries
	a_under_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == 3'(STAT_UNDER)) |-> (depth_left <= DEPTH_W'(1)))
		else $error("underflow with deep stack");

	// overflow only happens on a full stack
	a_over_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == 3'(STAT_OVER)) |-> (depth_left == DEPTH_W'(STACK_DEPTH)))
		else $error("overflow with stack not full");

endmodule

bind postfix_stack_evaluator pse_checker #(
	.STACK_DEPTH (STACK_DEPTH)
) u_pse_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_value (result_value),
	.status       (status),
	.depth_left   (depth_left),
	.empty        (empty),
	.pop          (pop)
);
`default_nettype wire

// ----- sim/tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the postfix stack evaluator
// ----------------------------------------------------------------------------
// symbols go in through the push/full queue port and results come back
// through the empty/pop queue port. a scoreboard keeps its own operand stack
// and error state, predicts one result for every symbol marked last, and
// compares each popped result field by field with the oldest prediction.
// a short directed part covers field extremes, every operator, underflow,
// bad symbols and divide by zero. random well-formed expressions, noise,
// overflow runs and arithmetic corners follow, under random sender bursts
// and receiver stalls, with one long receiver hold and several full drains.
// ----------------------------------------------------------------------------
module tb;
	import pse_pkg::*;

	localparam int STACK_DEPTH   = 16;
	localparam int DATA_WIDTH    = 32;
	localparam int SYMBOL_TARGET = 1900;
	localparam int LONG_HOLD     = 600;
	// a power with a 31-bit exponent is the slowest symbol
	localparam int SETTLE_CYCLES = 800;
	localparam int CYCLE_LIMIT   = 2000000;

	// one predicted result transaction
	typedef struct {
		logic signed [RESULT_W-1:0] value;
		status_t                    stat;
		logic [DEPTH_W-1:0]         depth;
	} expr_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// symbol side, known from time zero
	logic [7:0] symbol      = 8'd0;
	logic       last_symbol = 1'b0;
	logic       push        = 1'b0;
	logic       full;

	// result side
	logic signed [RESULT_W-1:0] result_value;
	logic [2:0]                 status;
	logic [DEPTH_W-1:0]         depth_left;
	logic                       empty;
	logic                       pop = 1'b0;

	// scoreboard: expected results and the evaluator state behind them
	expr_result_t pending_results[$];
	expr_result_t oldest;
	logic [DATA_WIDTH-1:0] eval_stack [STACK_DEPTH];
	int unsigned eval_depth = 0;
	status_t eval_fault = STAT_OK;

	// bookkeeping
	int mismatches      = 0;
	int results_checked = 0;
	int symbols_sent    = 0;
	int expressions     = 0;
	int status_seen [5] = '{default: 0};
	int cycle_count     = 0;

	// sender burst state
	int burst_left = 0;

	// receiver stall state
	int hold_requests = 0;
	int hold_granted  = 0;
	int hold_left     = 0;
	int rx_mode       = 0;
	int rx_mode_left  = 0;
	logic [15:0] rx_pattern = 16'hA5C3;

	postfix_stack_evaluator #(
		.STACK_DEPTH(STACK_DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.symbol      (symbol),
		.last_symbol (last_symbol),
		.push        (push),
		.full        (full),
		.result_value(result_value),
		.status      (status),
		.depth_left  (depth_left),
		.empty       (empty),
		.pop         (pop)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------------

	// square and multiply, wrapping; a negative exponent gives 1
	function automatic logic [DATA_WIDTH-1:0] wrap_power(input logic [DATA_WIDTH-1:0] base,
			input logic [DATA_WIDTH-1:0] expo);
		logic [DATA_WIDTH-1:0] acc;
		logic [DATA_WIDTH-1:0] sq;
		logic [DATA_WIDTH-1:0] e;
		acc = 1;
		if (expo[DATA_WIDTH-1])
			return acc;
		sq = base;
		e  = expo;
		while (e != 0) begin
			if (e[0])
				acc = acc * sq;
			sq = sq * sq;
			e  = e >> 1;
		end
		return acc;
	endfunction

	// first OP second; division works on magnitudes so that the most negative
	// value over -1 wraps instead of trapping
	function automatic status_t combine_operands(input logic [7:0] op,
			input logic [DATA_WIDTH-1:0] a, input logic [DATA_WIDTH-1:0] b,
			output logic [DATA_WIDTH-1:0] r);
		logic [DATA_WIDTH-1:0] ma;
		logic [DATA_WIDTH-1:0] mb;
		logic [DATA_WIDTH-1:0] q;
		r = '0;
		case (op)
			CH_PLUS:  r = a + b;
			CH_MINUS: r = a - b;
			CH_STAR:  r = a * b;
			CH_CARET: r = wrap_power(a, b);
			default: begin
				if (b == 0)
					return STAT_DIVZ;
				ma = a[DATA_WIDTH-1] ? -a : a;
				mb = b[DATA_WIDTH-1] ? -b : b;
				if (op == CH_SLASH) begin
					q = ma / mb;
					r = (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]) ? -q : q;
				end else begin
					// remainder follows the dividend's sign
					q = ma % mb;
					r = a[DATA_WIDTH-1] ? -q : q;
				end
			end
		endcase
		return STAT_OK;
	endfunction

	// apply one accepted symbol; a symbol marked last also yields a result
	task automatic advance_evaluation(input logic [7:0] sym, input logic fin);
		logic [DATA_WIDTH-1:0] a;
		logic [DATA_WIDTH-1:0] b;
		logic [DATA_WIDTH-1:0] r;
		status_t st;
		expr_result_t res;
		// first error sticks until the expression ends
		if (eval_fault == STAT_OK) begin
			case (sym)
				CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_CARET: begin
					if (eval_depth < 2) begin
						eval_fault = STAT_UNDER;
					end else begin
						b  = eval_stack[eval_depth-1];
						a  = eval_stack[eval_depth-2];
						st = combine_operands(sym, a, b, r);
						if (st != STAT_OK) begin
							eval_fault = st;
						end else begin
							eval_depth--;
							eval_stack[eval_depth-1] = r;
						end
					end
				end
				default: begin
					if (sym >= CH_ZERO && sym <= CH_NINE) begin
						// push onto a full stack leaves the stack as it was
						if (eval_depth >= STACK_DEPTH) begin
							eval_fault = STAT_OVER;
						end else begin
							eval_stack[eval_depth] = DATA_WIDTH'(sym - CH_ZERO);
							eval_depth++;
						end
					end else begin
						eval_fault = STAT_BAD;
					end
				end
			endcase
		end
		if (fin) begin
			res.value = '0;
			if (eval_fault == STAT_OK) begin
				if (eval_depth == 0) begin
					eval_fault = STAT_UNDER;
				end else begin
					eval_depth--;
					res.value = eval_stack[eval_depth];
				end
			end
			// on error the value is zero and the depth is held without a pop
			if (eval_fault != STAT_OK)
				res.value = '0;
			res.stat  = eval_fault;
			res.depth = eval_depth[DEPTH_W-1:0];
			pending_results.push_back(res);
			eval_depth = 0;
			eval_fault = STAT_OK;
			expressions++;
		end
	endtask

	// ------------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string what);
		mismatches++;
		// keep the log short when something is badly broken
		if (mismatches <= 100)
			$display("mismatch at result %0d: %s", results_checked, what);
	endtask

	// compare each popped result transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result value %0d status %0d depth %0d",
					result_value, status, depth_left));
			end else begin
				oldest = pending_results.pop_front();
				if (result_value !== oldest.value)
					report_mismatch($sformatf("result_value %0d, predicted %0d",
						result_value, oldest.value));
				if (status !== oldest.stat)
					report_mismatch($sformatf("status %0d, predicted %0d",
						status, oldest.stat));
				if (depth_left !== oldest.depth)
					report_mismatch($sformatf("depth_left %0d, predicted %0d",
						depth_left, oldest.depth));
				status_seen[oldest.stat]++;
			end
			results_checked++;
		end
	end

	// ------------------------------------------------------------------------
	// receiver: stall pattern of its own, plus a long hold on request
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_granted != hold_requests) begin
			// a test asked for a long hold, counted here in cycles
			hold_granted <= hold_requests;
			hold_left    <= LONG_HOLD;
			pop          <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			pop       <= 1'b0;
		end else begin
			case (rx_mode)
				0: pop <= 1'b1;                          // never stalls
				1: pop <= 1'($urandom_range(0, 1));      // coin flip
				2: pop <= ($urandom_range(0, 3) == 0);   // mostly stalled
				default: pop <= rx_pattern[0];           // fixed rotating mask
			endcase
		end
		// mode switches at random intervals so stalls fall on every phase
		if (rx_mode_left == 0) begin
			rx_mode      <= $urandom_range(0, 3);
			rx_mode_left <= $urandom_range(20, 300);
			rx_pattern   <= 16'($urandom);
		end else begin
			rx_mode_left <= rx_mode_left - 1;
			rx_pattern   <= {rx_pattern[0], rx_pattern[15:1]};
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected",
				cycle_count, pending_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// sender
	// ------------------------------------------------------------------------

	// offer one symbol transaction until it is taken, then maybe leave a gap
	task automatic send_symbol(input logic [7:0] sym, input logic fin);
		push        <= 1'b1;
		symbol      <= sym;
		last_symbol <= fin;
		do
			@(posedge clk);
		while (full);
		advance_evaluation(sym, fin);
		symbols_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			// end of burst: random gap, then a fresh burst length
			burst_left = $urandom_range(0, 40);
			push <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// a string of symbols; the final one carries the last mark if asked
	task automatic send_text(input string text, input bit close);
		int i;
		for (i = 0; i < text.len(); i++)
			send_symbol(text[i], close && (i == text.len() - 1));
	endtask

	// stop offering and wait until every predicted result has been popped
	task automatic wait_until_drained();
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] random_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] random_operator();
		case ($urandom_range(0, 5))
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_STAR;
			3: return CH_SLASH;
			4: return CH_PCT;
			default: return CH_CARET;
		endcase
	endfunction

	// one random expression: mostly well formed, the rest noise, stack
	// overflow runs and arithmetic corners
	task automatic send_random_expression();
		int kind;
		int goal;
		int cap;
		int height;
		int keep;
		int n;
		int i;
		int d;
		int e;
		kind = $urandom_range(0, 99);
		d    = $urandom_range(0, 9);
		e    = $urandom_range(0, 9);
		if (kind < 68) begin
			// well formed body with random digits and operators
			goal   = $urandom_range(1, 24);
			cap    = $urandom_range(2, STACK_DEPTH);
			height = 0;
			for (i = 0; i < goal; i++) begin
				if (height < 2 || (height < cap && $urandom_range(0, 1) == 1)) begin
					send_symbol(random_digit(), 1'b0);
					height++;
				end else begin
					send_symbol(random_operator(), 1'b0);
					height--;
				end
			end
			if (height == 0) begin
				send_symbol(random_digit(), 1'b0);
				height = 1;
			end
			// close down to one entry, or leave some behind now and then
			keep = ($urandom_range(0, 3) == 0) ? $urandom_range(1, height) : 1;
			n    = height - keep;
			if (n <= 0) begin
				send_symbol(random_digit(), 1'b1);
			end else begin
				for (i = 1; i <= n; i++)
					send_symbol(random_operator(), i == n);
			end
		end else if (kind < 82) begin
			// noise: any byte, with digits and operators mixed in
			n = $urandom_range(1, 6);
			for (i = 1; i <= n; i++) begin
				case ($urandom_range(0, 3))
					0: send_symbol(random_digit(), i == n);
					1: send_symbol(random_operator(), i == n);
					default: send_symbol(8'($urandom_range(0, 255)), i == n);
				endcase
			end
		end else if (kind < 90) begin
			// push at least a full stack of digits, then one more digit or an operator
			n = $urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 3);
			for (i = 1; i < n; i++)
				send_symbol(random_digit(), 1'b0);
			if ($urandom_range(0, 1) == 1)
				send_symbol(random_digit(), 1'b1);
			else
				send_symbol(random_operator(), 1'b1);
		end else begin
			// arithmetic corners; 2 ^ 31 builds the most negative value
			case ($urandom_range(0, 6))
				0: send_text("293*4+^01-/", 1'b1);
				1: send_text("293*4+^01-%", 1'b1);
				2: send_text($sformatf("293*4+^1-%0d+", d), 1'b1);
				3: send_text($sformatf("%0d01-^", d), 1'b1);
				4: send_text($sformatf("0%0d-%0d/", d, e), 1'b1);
				5: send_text($sformatf("0%0d-%0d%%", d, e), 1'b1);
				default: send_text("99*9*9*9*9*9*9*9*9*9*", 1'b1);
			endcase
		end
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// lowest and highest symbol codes, a bad byte inside an expression, and
	// an expression that ends with entries left over
	task automatic test_field_extremes();
		send_symbol(8'h00, 1'b1);
		send_text("1", 1'b0);
		send_symbol(8'hFF, 1'b0);
		send_text("2+", 1'b1);
		send_text("49", 1'b1);
	endtask

	// every operator once in a single chain: ((9+3-4)*6 % 7 / 2) ^ 3
	task automatic test_every_operator();
		send_text("93+4-6*7%2/3^", 1'b1);
	endtask

	// operator on an empty stack, and a zero divisor
	task automatic test_error_codes();
		send_text("+", 1'b1);
		send_text("50/", 1'b1);
		wait_until_drained();
	endtask

	task automatic test_random_traffic();
		while (symbols_sent < SYMBOL_TARGET - 600)
			send_random_expression();
	endtask

	// receiver holds off while the sender keeps offering, so full must rise
	task automatic test_receiver_hold();
		int start;
		start = symbols_sent;
		hold_requests <= hold_requests + 1;
		burst_left = 1000;
		while (symbols_sent < start + 250)
			send_random_expression();
		burst_left = 0;
	endtask

	// sender pauses until every result is back, every few expressions
	task automatic test_drain_pauses();
		int count;
		count = 0;
		while (symbols_sent < SYMBOL_TARGET) begin
			send_random_expression();
			count++;
			if (count % 5 == 0)
				wait_until_drained();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_every_operator();
		test_error_codes();
		test_random_traffic();
		test_receiver_hold();
		test_drain_pauses();

		wait_until_drained();
		// anything the block still emits now shows up as unexpected
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d symbols in %0d expressions, %0d results checked, %0d mismatches",
			symbols_sent, expressions, results_checked, mismatches);
		$display("statuses: ok %0d, underflow %0d, overflow %0d, div by zero %0d, bad %0d",
			status_seen[STAT_OK], status_seen[STAT_UNDER], status_seen[STAT_OVER],
			status_seen[STAT_DIVZ], status_seen[STAT_BAD]);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire
